@@ rtl/ope_pkg.sv @@
// ope_pkg: types, constants, microcode and arithmetic helpers for the
// orthogonal polynomial evaluator; depends on nothing, used by every rtl file
`default_nettype none

package ope_pkg;

  localparam int VAL_W      = 48;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_DEGREE = 15;
  localparam int DEG_W      = 4;
  localparam int CMD_W      = 3;
  localparam int POINT_W    = 22;
  localparam int SHAPE_W    = 24;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int MUL_CHUNKS = 3;
  localparam int MUL_CW     = VAL_W / MUL_CHUNKS;
  localparam int MCH_W      = $clog2(MUL_CHUNKS);
  localparam int DIV_W      = VAL_W + FRAC_BITS + 1;
  localparam int CNT_W      = $clog2(DIV_W);
  localparam int PC_W       = 6;
  localparam int SHAMT_W    = $clog2(FRAC_BITS + 2);

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam val_t ONE_V   = val_t'(1) << FRAC_BITS;
  localparam val_t TWO_V   = val_t'(2) << FRAC_BITS;
  localparam logic [PROD_W:0] NEG_MAG = (PROD_W+1)'(1) << (VAL_W - 1);
  localparam logic [PROD_W:0] POS_MAG = NEG_MAG - (PROD_W+1)'(1);

  typedef enum logic [CMD_W-1:0] {
    FAM_HERMITE      = 3'd0,
    FAM_JACOBI       = 3'd1,
    FAM_LEGENDRE     = 3'd2,
    FAM_LAGUERRE     = 3'd3,
    FAM_GEN_LAGUERRE = 3'd4
  } fam_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_TWO, SRC_X, SRC_A, SRC_B, SRC_CUR, SRC_LAST,
    SRC_S, SRC_C, SRC_DEN, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5,
    SRC_KQ, SRC_K2Q, SRC_IQ, SRC_ODDQ, SRC_I, SRC_ODD, SRC_IP1
  } src_t;

  typedef enum logic [3:0] {
    D_S, D_C, D_DEN, D_T1, D_T2, D_T3, D_T4, D_T5, D_CUR, D_UPD
  } dst_t;

  typedef enum logic [1:0] {SH_NONE, SH_FRAC, SH_FRAC1} sh_t;

  typedef struct packed {
    op_t  op;
    src_t sa;
    src_t sb;
    dst_t dst;
    sh_t  sh;
    logic eos;
  } uop_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_BUSY, ST_DONE} ctrl_state_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_MUL, PH_MUL_FIN, PH_DIV, PH_DIV_FIN
  } dp_phase_t;

  typedef struct packed {
    logic             load;
    logic             load_zero;
    logic             start;
    logic             capture;
    uop_t             uop;
    logic [DEG_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  typedef struct packed {
    val_t v;
    logic ovf;
  } sat_t;

  function automatic uop_t mk(input op_t op, input src_t sa, input src_t sb,
                              input dst_t dst, input sh_t sh, input logic eos);
    uop_t u;
    u.op  = op;
    u.sa  = sa;
    u.sb  = sb;
    u.dst = dst;
    u.sh  = sh;
    u.eos = eos;
    return u;
  endfunction

  function automatic logic [PC_W-1:0] first_pc(input logic [CMD_W-1:0] fam);
    logic [PC_W-1:0] r;
    case (fam)
      FAM_HERMITE:  r = PC_W'(0);
      FAM_JACOBI:   r = PC_W'(4);
      FAM_LEGENDRE: r = PC_W'(36);
      FAM_LAGUERRE: r = PC_W'(42);
      default:      r = PC_W'(48);
    endcase
    return r;
  endfunction

  function automatic logic [PC_W-1:0] step_pc(input logic [CMD_W-1:0] fam);
    logic [PC_W-1:0] r;
    case (fam)
      FAM_HERMITE:  r = PC_W'(1);
      FAM_JACOBI:   r = PC_W'(10);
      FAM_LEGENDRE: r = PC_W'(37);
      FAM_LAGUERRE: r = PC_W'(43);
      default:      r = PC_W'(50);
    endcase
    return r;
  endfunction

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // hermite
      6'd0:  u = mk(OP_ADD, SRC_X,    SRC_ZERO, D_CUR, SH_NONE,  1'b1);
      6'd1:  u = mk(OP_MUL, SRC_X,    SRC_CUR,  D_T1,  SH_FRAC,  1'b0);
      6'd2:  u = mk(OP_MUL, SRC_LAST, SRC_I,    D_T2,  SH_NONE,  1'b0);
      6'd3:  u = mk(OP_SUB, SRC_T1,   SRC_T2,   D_UPD, SH_NONE,  1'b1);
      // jacobi first
      6'd4:  u = mk(OP_ADD, SRC_A,    SRC_ONE,  D_T1,  SH_NONE,  1'b0);
      6'd5:  u = mk(OP_ADD, SRC_A,    SRC_B,    D_T2,  SH_NONE,  1'b0);
      6'd6:  u = mk(OP_ADD, SRC_T2,   SRC_TWO,  D_T2,  SH_NONE,  1'b0);
      6'd7:  u = mk(OP_SUB, SRC_X,    SRC_ONE,  D_T3,  SH_NONE,  1'b0);
      6'd8:  u = mk(OP_MUL, SRC_T2,   SRC_T3,   D_T3,  SH_FRAC1, 1'b0);
      6'd9:  u = mk(OP_ADD, SRC_T1,   SRC_T3,   D_CUR, SH_NONE,  1'b1);
      // jacobi step
      6'd10: u = mk(OP_ADD, SRC_A,    SRC_B,    D_S,   SH_NONE,  1'b0);
      6'd11: u = mk(OP_ADD, SRC_K2Q,  SRC_S,    D_C,   SH_NONE,  1'b0);
      6'd12: u = mk(OP_SUB, SRC_C,    SRC_ONE,  D_T1,  SH_NONE,  1'b0);
      6'd13: u = mk(OP_SUB, SRC_C,    SRC_TWO,  D_T2,  SH_NONE,  1'b0);
      6'd14: u = mk(OP_ADD, SRC_KQ,   SRC_S,    D_T3,  SH_NONE,  1'b0);
      6'd15: u = mk(OP_MUL, SRC_K2Q,  SRC_T3,   D_T3,  SH_FRAC,  1'b0);
      6'd16: u = mk(OP_MUL, SRC_T3,   SRC_T2,   D_DEN, SH_FRAC,  1'b0);
      6'd17: u = mk(OP_MUL, SRC_A,    SRC_A,    D_T4,  SH_FRAC,  1'b0);
      6'd18: u = mk(OP_MUL, SRC_B,    SRC_B,    D_T5,  SH_FRAC,  1'b0);
      6'd19: u = mk(OP_SUB, SRC_T4,   SRC_T5,   D_T4,  SH_NONE,  1'b0);
      6'd20: u = mk(OP_MUL, SRC_C,    SRC_T2,   D_T5,  SH_FRAC,  1'b0);
      6'd21: u = mk(OP_MUL, SRC_T5,   SRC_X,    D_T5,  SH_FRAC,  1'b0);
      6'd22: u = mk(OP_ADD, SRC_T5,   SRC_T4,   D_T5,  SH_NONE,  1'b0);
      6'd23: u = mk(OP_MUL, SRC_T1,   SRC_T5,   D_T1,  SH_FRAC,  1'b0);
      6'd24: u = mk(OP_ADD, SRC_KQ,   SRC_A,    D_T4,  SH_NONE,  1'b0);
      6'd25: u = mk(OP_SUB, SRC_T4,   SRC_ONE,  D_T4,  SH_NONE,  1'b0);
      6'd26: u = mk(OP_MUL, SRC_TWO,  SRC_T4,   D_T4,  SH_FRAC,  1'b0);
      6'd27: u = mk(OP_ADD, SRC_KQ,   SRC_B,    D_T5,  SH_NONE,  1'b0);
      6'd28: u = mk(OP_SUB, SRC_T5,   SRC_ONE,  D_T5,  SH_NONE,  1'b0);
      6'd29: u = mk(OP_MUL, SRC_T4,   SRC_T5,   D_T4,  SH_FRAC,  1'b0);
      6'd30: u = mk(OP_MUL, SRC_T4,   SRC_C,    D_T4,  SH_FRAC,  1'b0);
      6'd31: u = mk(OP_DIV, SRC_T1,   SRC_DEN,  D_T1,  SH_FRAC,  1'b0);
      6'd32: u = mk(OP_DIV, SRC_T4,   SRC_DEN,  D_T4,  SH_FRAC,  1'b0);
      6'd33: u = mk(OP_MUL, SRC_T1,   SRC_CUR,  D_T1,  SH_FRAC,  1'b0);
      6'd34: u = mk(OP_MUL, SRC_T4,   SRC_LAST, D_T4,  SH_FRAC,  1'b0);
      // 35 is the jacobi step's closing subtract, legendre starts after it
      6'd35: u = mk(OP_SUB, SRC_T1,   SRC_T4,   D_UPD, SH_NONE,  1'b1);
      default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, D_T1, SH_NONE, 1'b1);
    endcase
    return u;
  endfunction

  function automatic uop_t ucode_hi(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // legendre
      6'd36: u = mk(OP_ADD, SRC_X,    SRC_ZERO, D_CUR, SH_NONE,  1'b1);
      6'd37: u = mk(OP_MUL, SRC_X,    SRC_CUR,  D_T1,  SH_FRAC,  1'b0);
      6'd38: u = mk(OP_MUL, SRC_T1,   SRC_ODD,  D_T1,  SH_NONE,  1'b0);
      6'd39: u = mk(OP_MUL, SRC_LAST, SRC_I,    D_T2,  SH_NONE,  1'b0);
      6'd40: u = mk(OP_SUB, SRC_T1,   SRC_T2,   D_T1,  SH_NONE,  1'b0);
      6'd41: u = mk(OP_DIV, SRC_T1,   SRC_IP1,  D_UPD, SH_NONE,  1'b1);
      // laguerre
      6'd42: u = mk(OP_SUB, SRC_ONE,  SRC_X,    D_CUR, SH_NONE,  1'b1);
      6'd43: u = mk(OP_SUB, SRC_ODDQ, SRC_X,    D_T1,  SH_NONE,  1'b0);
      6'd44: u = mk(OP_MUL, SRC_T1,   SRC_CUR,  D_T1,  SH_FRAC,  1'b0);
      6'd45: u = mk(OP_MUL, SRC_LAST, SRC_I,    D_T2,  SH_NONE,  1'b0);
      6'd46: u = mk(OP_SUB, SRC_T1,   SRC_T2,   D_T1,  SH_NONE,  1'b0);
      6'd47: u = mk(OP_DIV, SRC_T1,   SRC_IP1,  D_UPD, SH_NONE,  1'b1);
      // generalized laguerre
      6'd48: u = mk(OP_ADD, SRC_ONE,  SRC_A,    D_T1,  SH_NONE,  1'b0);
      6'd49: u = mk(OP_SUB, SRC_T1,   SRC_X,    D_CUR, SH_NONE,  1'b1);
      6'd50: u = mk(OP_ADD, SRC_ODDQ, SRC_A,    D_T1,  SH_NONE,  1'b0);
      6'd51: u = mk(OP_SUB, SRC_T1,   SRC_X,    D_T1,  SH_NONE,  1'b0);
      6'd52: u = mk(OP_MUL, SRC_T1,   SRC_CUR,  D_T1,  SH_FRAC,  1'b0);
      6'd53: u = mk(OP_ADD, SRC_IQ,   SRC_A,    D_T2,  SH_NONE,  1'b0);
      6'd54: u = mk(OP_MUL, SRC_T2,   SRC_LAST, D_T2,  SH_FRAC,  1'b0);
      6'd55: u = mk(OP_SUB, SRC_T1,   SRC_T2,   D_T1,  SH_NONE,  1'b0);
      6'd56: u = mk(OP_DIV, SRC_T1,   SRC_IP1,  D_UPD, SH_NONE,  1'b1);
      default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, D_T1, SH_NONE, 1'b1);
    endcase
    return u;
  endfunction

  function automatic uop_t fetch(input logic [PC_W-1:0] pc);
    return (pc > PC_W'(35)) ? ucode_hi(pc) : ucode(pc);
  endfunction

  function automatic sat_t sat_mag(input logic neg, input logic [PROD_W:0] m);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (m > NEG_MAG) begin
        r.v   = VAL_MIN;
        r.ovf = 1'b1;
      end else begin
        r.v = -val_t'(m[VAL_W-1:0]);
      end
    end else begin
      if (m > POS_MAG) begin
        r.v   = VAL_MAX;
        r.ovf = 1'b1;
      end else begin
        r.v = val_t'(m[VAL_W-1:0]);
      end
    end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] mag(input val_t v);
    return v[VAL_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ope_if.sv @@
// ope_in_if and ope_out_if: valid/ready channels for input and result words
// depends on ope_pkg for field widths
`default_nettype none

interface ope_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [ope_pkg::CMD_W-1:0]              cmd;
  logic [ope_pkg::DEG_W-1:0]              degree;
  logic signed [ope_pkg::POINT_W-1:0]     point;
  logic signed [ope_pkg::SHAPE_W-1:0]     param_alpha;
  logic signed [ope_pkg::SHAPE_W-1:0]     param_beta;
  modport source (output valid, cmd, degree, point, param_alpha, param_beta,
                  input ready);
  modport sink (input valid, cmd, degree, point, param_alpha, param_beta,
                output ready);
endinterface

interface ope_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [47:0]   poly_value;
  logic                 saturated;
  modport source (output valid, poly_value, saturated, input ready);
  modport sink (input valid, poly_value, saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/ope_dp.sv @@
// ope_dp: operand registers, shared add/sub, sequential multiplier, radix-2
// divider and result register; depends on ope_pkg, driven by ope_ctrl
`default_nettype none

module ope_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ope_pkg::dp_cmd_t                   cmd,
  output ope_pkg::dp_stat_t                  stat,
  input  logic signed [ope_pkg::POINT_W-1:0] point,
  input  logic signed [ope_pkg::SHAPE_W-1:0] param_alpha,
  input  logic signed [ope_pkg::SHAPE_W-1:0] param_beta,
  output ope_pkg::val_t                      poly_value,
  output logic                               saturated
);

  ope_pkg::val_t x, alpha, beta, cur, last, s, c, den, t1, t2, t3, t4, t5;
  ope_pkg::val_t kk, kq, k2q, iq, oddq, ii, odd, ip1;
  ope_pkg::val_t opa, opb;
  logic sat;
  ope_pkg::dp_phase_t phase;
  ope_pkg::dst_t dst_r, wdst;
  ope_pkg::sh_t sh_r;
  logic neg_r;
  logic [ope_pkg::CNT_W-1:0] cnt;
  logic [ope_pkg::MCH_W-1:0] mcnt;
  logic [ope_pkg::VAL_W-1:0] ma, mb, md, rem, rem_next;
  logic [ope_pkg::PROD_W-1:0] acc, acc_next;
  logic [ope_pkg::VAL_W+ope_pkg::MUL_CW-1:0] part;
  logic [ope_pkg::DIV_W-1:0] dv;
  logic [ope_pkg::DIV_W:0] q;
  logic [ope_pkg::DIV_W+1:0] qr;
  logic [ope_pkg::VAL_W:0] r2;
  logic ge, big, rnd_up;
  logic signed [ope_pkg::VAL_W:0] sum;
  logic [ope_pkg::PROD_W:0] t_rnd, rnd_add;
  logic [ope_pkg::SHAMT_W-1:0] shamt;
  logic wr_en, wr_ovf;
  ope_pkg::val_t wr_val;
  ope_pkg::sat_t mres, dres;

  always_comb begin
    kk   = ope_pkg::val_t'(cmd.k);
    kq   = kk <<< ope_pkg::FRAC_BITS;
    k2q  = kq <<< 1;
    ii   = kk - ope_pkg::val_t'(1);
    iq   = ii <<< ope_pkg::FRAC_BITS;
    odd  = (kk <<< 1) - ope_pkg::val_t'(1);
    oddq = odd <<< ope_pkg::FRAC_BITS;
    ip1  = kk;
  end

  function automatic ope_pkg::val_t src_mux(input ope_pkg::src_t sel);
    ope_pkg::val_t v;
    case (sel)
      ope_pkg::SRC_ZERO: v = '0;
      ope_pkg::SRC_ONE:  v = ope_pkg::ONE_V;
      ope_pkg::SRC_TWO:  v = ope_pkg::TWO_V;
      ope_pkg::SRC_X:    v = x;
      ope_pkg::SRC_A:    v = alpha;
      ope_pkg::SRC_B:    v = beta;
      ope_pkg::SRC_CUR:  v = cur;
      ope_pkg::SRC_LAST: v = last;
      ope_pkg::SRC_S:    v = s;
      ope_pkg::SRC_C:    v = c;
      ope_pkg::SRC_DEN:  v = den;
      ope_pkg::SRC_T1:   v = t1;
      ope_pkg::SRC_T2:   v = t2;
      ope_pkg::SRC_T3:   v = t3;
      ope_pkg::SRC_T4:   v = t4;
      ope_pkg::SRC_T5:   v = t5;
      ope_pkg::SRC_KQ:   v = kq;
      ope_pkg::SRC_K2Q:  v = k2q;
      ope_pkg::SRC_IQ:   v = iq;
      ope_pkg::SRC_ODDQ: v = oddq;
      ope_pkg::SRC_I:    v = ii;
      ope_pkg::SRC_ODD:  v = odd;
      ope_pkg::SRC_IP1:  v = ip1;
      default:           v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = src_mux(cmd.uop.sa);
    opb = src_mux(cmd.uop.sb);
    if (cmd.uop.op == ope_pkg::OP_SUB) begin
      sum = {opa[ope_pkg::VAL_W-1], opa} - {opb[ope_pkg::VAL_W-1], opb};
    end else begin
      sum = {opa[ope_pkg::VAL_W-1], opa} + {opb[ope_pkg::VAL_W-1], opb};
    end
  end

  // multiplier partial product and rounding
  always_comb begin
    mcnt     = cnt[ope_pkg::MCH_W-1:0];
    part     = ma * mb[mcnt*ope_pkg::MUL_CW +: ope_pkg::MUL_CW];
    acc_next = acc + (ope_pkg::PROD_W'(part) << (mcnt * ope_pkg::MUL_CW));
    case (sh_r)
      ope_pkg::SH_FRAC: begin
        rnd_add = (ope_pkg::PROD_W+1)'(1) << (ope_pkg::FRAC_BITS - 1);
        shamt   = ope_pkg::SHAMT_W'(ope_pkg::FRAC_BITS);
      end
      ope_pkg::SH_FRAC1: begin
        rnd_add = (ope_pkg::PROD_W+1)'(1) << ope_pkg::FRAC_BITS;
        shamt   = ope_pkg::SHAMT_W'(ope_pkg::FRAC_BITS + 1);
      end
      default: begin
        rnd_add = '0;
        shamt   = '0;
      end
    endcase
    t_rnd = {1'b0, acc} + rnd_add;
    mres  = ope_pkg::sat_mag(neg_r, t_rnd >> shamt);
  end

  // divider step and final rounding
  always_comb begin
    r2       = {rem, dv[ope_pkg::DIV_W-1]};
    ge       = r2 >= {1'b0, md};
    rem_next = ge ? ope_pkg::VAL_W'(r2 - {1'b0, md}) : r2[ope_pkg::VAL_W-1:0];
    big      = q > ((ope_pkg::DIV_W+1)'(1) << ope_pkg::VAL_W);
    rnd_up   = {rem, 1'b0} >= {1'b0, md};
    qr       = {1'b0, q} + (ope_pkg::DIV_W+2)'(rnd_up);
    if (big) begin
      dres = ope_pkg::sat_mag(neg_r, (ope_pkg::PROD_W+1)'(1) << ope_pkg::VAL_W);
    end else begin
      dres = ope_pkg::sat_mag(neg_r, (ope_pkg::PROD_W+1)'(qr));
    end
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_val = '0;
    wr_ovf = 1'b0;
    wdst   = dst_r;
    case (phase)
      ope_pkg::PH_IDLE: begin
        wdst = cmd.uop.dst;
        if (cmd.start && (cmd.uop.op == ope_pkg::OP_ADD ||
                          cmd.uop.op == ope_pkg::OP_SUB)) begin
          wr_en = 1'b1;
          if (sum[ope_pkg::VAL_W] != sum[ope_pkg::VAL_W-1]) begin
            wr_ovf = 1'b1;
            wr_val = sum[ope_pkg::VAL_W] ? ope_pkg::VAL_MIN : ope_pkg::VAL_MAX;
          end else begin
            wr_val = sum[ope_pkg::VAL_W-1:0];
          end
        end else if (cmd.start && cmd.uop.op == ope_pkg::OP_DIV && opb == '0) begin
          wr_en  = 1'b1;
          wr_ovf = 1'b1;
          if (opa == '0) begin
            wr_val = '0;
          end else begin
            wr_val = opa[ope_pkg::VAL_W-1] ? ope_pkg::VAL_MIN : ope_pkg::VAL_MAX;
          end
        end
      end
      ope_pkg::PH_MUL_FIN: begin
        wr_en  = 1'b1;
        wr_val = mres.v;
        wr_ovf = mres.ovf;
      end
      ope_pkg::PH_DIV_FIN: begin
        wr_en  = 1'b1;
        wr_val = dres.v;
        wr_ovf = dres.ovf;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ope_pkg::PH_IDLE;
      stat.done <= 1'b0;
    end else begin
      stat.done <= wr_en;
      case (phase)
        ope_pkg::PH_IDLE: begin
          if (cmd.start && cmd.uop.op == ope_pkg::OP_MUL) begin
            phase <= ope_pkg::PH_MUL;
          end else if (cmd.start && cmd.uop.op == ope_pkg::OP_DIV && opb != '0) begin
            phase <= ope_pkg::PH_DIV;
          end
        end
        ope_pkg::PH_MUL: begin
          if (cnt == ope_pkg::CNT_W'(ope_pkg::MUL_CHUNKS - 1)) begin
            phase <= ope_pkg::PH_MUL_FIN;
          end
        end
        ope_pkg::PH_DIV: begin
          if (cnt == ope_pkg::CNT_W'(ope_pkg::DIV_W - 1)) begin
            phase <= ope_pkg::PH_DIV_FIN;
          end
        end
        default: begin
          phase <= ope_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == ope_pkg::PH_IDLE && cmd.start) begin
      dst_r <= cmd.uop.dst;
      sh_r  <= cmd.uop.sh;
      neg_r <= opa[ope_pkg::VAL_W-1] ^ opb[ope_pkg::VAL_W-1];
      cnt   <= '0;
      ma    <= ope_pkg::mag(opa);
      mb    <= ope_pkg::mag(opb);
      md    <= ope_pkg::mag(opb);
      acc   <= '0;
      rem   <= '0;
      q     <= '0;
      case (cmd.uop.sh)
        ope_pkg::SH_FRAC:  dv <= ope_pkg::DIV_W'(ope_pkg::mag(opa)) << ope_pkg::FRAC_BITS;
        ope_pkg::SH_FRAC1: dv <= ope_pkg::DIV_W'(ope_pkg::mag(opa)) << (ope_pkg::FRAC_BITS + 1);
        default:           dv <= ope_pkg::DIV_W'(ope_pkg::mag(opa));
      endcase
    end else if (phase == ope_pkg::PH_MUL) begin
      acc <= acc_next;
      cnt <= cnt + 1'b1;
    end else if (phase == ope_pkg::PH_DIV) begin
      rem <= rem_next;
      q   <= {q[ope_pkg::DIV_W-1:0], ge};
      dv  <= dv << 1;
      cnt <= cnt + 1'b1;
    end

    if (cmd.load) begin
      x     <= ope_pkg::val_t'(point);
      alpha <= ope_pkg::val_t'(param_alpha);
      beta  <= ope_pkg::val_t'(param_beta);
      last  <= ope_pkg::ONE_V;
      cur   <= cmd.load_zero ? '0 : ope_pkg::ONE_V;
      sat   <= 1'b0;
    end else if (wr_en) begin
      sat <= sat | wr_ovf;
      case (wdst)
        ope_pkg::D_S:   s   <= wr_val;
        ope_pkg::D_C:   c   <= wr_val;
        ope_pkg::D_DEN: den <= wr_val;
        ope_pkg::D_T1:  t1  <= wr_val;
        ope_pkg::D_T2:  t2  <= wr_val;
        ope_pkg::D_T3:  t3  <= wr_val;
        ope_pkg::D_T4:  t4  <= wr_val;
        ope_pkg::D_T5:  t5  <= wr_val;
        ope_pkg::D_CUR: cur <= wr_val;
        ope_pkg::D_UPD: begin
          last <= cur;
          cur  <= wr_val;
        end
        default: t1 <= wr_val;
      endcase
    end

    if (cmd.capture) begin
      poly_value <= cur;
      saturated  <= sat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ope_ctrl.sv @@
// ope_ctrl: sequencer that walks the per-family microcode and the degree loop
// and owns the handshakes; depends on ope_pkg, drives ope_dp
`default_nettype none

module ope_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ope_pkg::CMD_W-1:0]        in_cmd,
  input  logic [ope_pkg::DEG_W-1:0]        in_degree,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ope_pkg::dp_cmd_t                 cmd,
  input  ope_pkg::dp_stat_t                stat
);

  ope_pkg::ctrl_state_t state, state_next;
  logic [ope_pkg::PC_W-1:0] pc, pc_next;
  logic [ope_pkg::DEG_W-1:0] k, k_next, deg, deg_in;
  logic [ope_pkg::CMD_W-1:0] fam;
  logic accept, special;
  ope_pkg::uop_t uop;

  always_comb begin
    deg_in  = (in_degree > ope_pkg::DEG_W'(ope_pkg::MAX_DEGREE)) ?
              ope_pkg::DEG_W'(ope_pkg::MAX_DEGREE) : in_degree;
    accept  = in_valid && in_ready;
    special = (in_cmd > ope_pkg::FAM_GEN_LAGUERRE) || (deg_in == '0);
    uop     = ope_pkg::fetch(pc);
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    k_next     = k;
    case (state)
      ope_pkg::ST_IDLE: begin
        if (accept) begin
          pc_next    = ope_pkg::first_pc(in_cmd);
          k_next     = ope_pkg::DEG_W'(1);
          state_next = special ? ope_pkg::ST_DONE : ope_pkg::ST_ISSUE;
        end
      end
      ope_pkg::ST_ISSUE: begin
        state_next = ope_pkg::ST_BUSY;
      end
      ope_pkg::ST_BUSY: begin
        if (stat.done) begin
          if (!uop.eos) begin
            pc_next    = pc + 1'b1;
            state_next = ope_pkg::ST_ISSUE;
          end else if (k == deg) begin
            state_next = ope_pkg::ST_DONE;
          end else begin
            k_next     = k + 1'b1;
            pc_next    = ope_pkg::step_pc(fam);
            state_next = ope_pkg::ST_ISSUE;
          end
        end
      end
      ope_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ope_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ope_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state == ope_pkg::ST_IDLE);
    cmd.load      = accept;
    cmd.load_zero = in_cmd > ope_pkg::FAM_GEN_LAGUERRE;
    cmd.start     = (state == ope_pkg::ST_ISSUE);
    cmd.capture   = (state == ope_pkg::ST_DONE) && (!out_valid || out_ready);
    cmd.uop       = uop;
    cmd.k         = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ope_pkg::ST_IDLE;
      out_valid <= 1'b0;
      pc        <= '0;
      k         <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      k     <= k_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      deg <= deg_in;
      fam <= in_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ope_pkg::ST_IDLE)
    else $error("accepted word did not start processing");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ope_pkg::ST_BUSY)
    else $error("datapath completion outside busy state");

  a_capture_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ope_pkg::ST_BUSY |-> (k <= deg && k != '0))
    else $error("degree counter out of range");

  a_start_one_cycle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !cmd.start)
    else $error("operation issued twice in a row");
`endif

endmodule

`default_nettype wire

@@ rtl/orthogonal_polynomial_eval_core.sv @@
// orthogonal polynomial evaluator top level: one word in, one word out.
// degree 0 or an unknown family goes straight to the result; otherwise each
// degree step runs the family's microcode of adds, multiplies (48x16 multiplier)
// and divides (radix-2 divider). one word in flight; the next word is taken
// while a result waits. sync reset clears control
`default_nettype none

module orthogonal_polynomial_eval_core (
  input  logic      clk,
  input  logic      rst,
  ope_in_if.sink    req,
  ope_out_if.source rsp
);

  ope_pkg::dp_cmd_t  cmd;
  ope_pkg::dp_stat_t stat;
  ope_pkg::val_t     value;

  ope_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_cmd    (req.cmd),
    .in_degree (req.degree),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ope_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .point       (req.point),
    .param_alpha (req.param_alpha),
    .param_beta  (req.param_beta),
    .poly_value  (value),
    .saturated   (rsp.saturated)
  );

  assign rsp.poly_value = value;

endmodule

`default_nettype wire
